FILE: rtl/core/rpsp_pkg.sv
package rpsp_pkg;

    // Widths of the values that move through the pipeline.
    typedef logic [7:0]  level_t;
    typedef logic [9:0]  duty_t;
    typedef logic [9:0]  time_t;
    typedef logic [2:0]  mask_t;
    typedef logic [11:0] sum_t;
    typedef logic [16:0] rem_t;

    localparam int QUOT_BITS = 6;
    typedef logic [QUOT_BITS-1:0] quot_t;

    // Channel duties plus the decision to scale them, carried past the divider.
    typedef struct packed {
        duty_t red;
        duty_t green;
        duty_t blue;
        logic  limit;
    } chan_t;

    // One turn-on event: its time and the LEDs it affects.
    typedef struct packed {
        time_t tm;
        mask_t mk;
    } slot_t;

    localparam sum_t  LIMIT_SUM = 12'd1600;
    localparam rem_t  DIV_NUM   = 17'd102400;
    localparam time_t FULL_TIME = 10'd1023;

    localparam mask_t MASK_RED   = 3'b100;
    localparam mask_t MASK_GREEN = 3'b010;
    localparam mask_t MASK_BLUE  = 3'b001;

    // Three-piece linear gamma curve: slope 1, then 3, then 6.
    function automatic duty_t gamma_expand(input level_t c);
        logic [10:0] cx;
        logic [10:0] res;
        cx = {3'b000, c};
        if (c[7]) begin
            res = cx * 11'd6 - 11'd507;
        end
        else if (c[6]) begin
            res = cx * 11'd3 - 11'd126;
        end
        else begin
            res = cx;
        end
        return res[9:0];
    endfunction

    // Blue duty becomes floor(14 * (b + 1) / 16).
    function automatic duty_t blue_scale(input duty_t b);
        logic [13:0] p;
        p = ({4'b0000, b} + 14'd1) * 14'd14;
        return p[13:4];
    endfunction

    // Compare-exchange: the later slot takes the larger time, ties stay put.
    function automatic logic slot_swap(input slot_t a, input slot_t b);
        return a.tm > b.tm;
    endfunction

endpackage

FILE: rtl/core/rpsp_if.sv
interface rpsp_color_if;
    import rpsp_pkg::*;
    logic   valid;
    logic   ready;
    level_t red_level;
    level_t green_level;
    level_t blue_level;

    modport source (output valid, output red_level, output green_level,
                    output blue_level, input ready);
    modport sink   (input valid, input red_level, input green_level,
                    input blue_level, output ready);
endinterface

interface rpsp_plan_if;
    import rpsp_pkg::*;
    logic  valid;
    logic  ready;
    time_t first_time;
    mask_t first_mask;
    time_t second_time;
    mask_t second_mask;
    time_t third_time;
    mask_t third_mask;

    modport source (output valid, output first_time, output first_mask,
                    output second_time, output second_mask,
                    output third_time, output third_mask, input ready);
    modport sink   (input valid, input first_time, input first_mask,
                    input second_time, input second_mask,
                    input third_time, input third_mask, output ready);
endinterface

interface rpsp_cfg_if;
    logic valid;
    logic ready;
    logic current_limit_enable;

    modport source (output valid, output current_limit_enable, input ready);
    modport sink   (input valid, input current_limit_enable, output ready);
endinterface

FILE: rtl/core/rpsp_divider.sv
// Restoring divider of DIV_NUM by the channel sum, one quotient bit per stage.
module rpsp_divider
    import rpsp_pkg::*;
(
    input  logic                 clk,
    input  logic [QUOT_BITS-1:0] adv,
    input  sum_t                 div_in,
    input  chan_t                side_in,
    output quot_t                quot_out,
    output chan_t                side_out
);

    rem_t  rem_reg  [QUOT_BITS];
    quot_t quot_reg [QUOT_BITS];
    sum_t  div_reg  [QUOT_BITS];
    chan_t side_reg [QUOT_BITS];

    for (genvar k = 0; k < QUOT_BITS; k++) begin : g_stage
        localparam int BIT = QUOT_BITS - 1 - k;

        rem_t  rem_prev;
        quot_t quot_prev;
        sum_t  div_prev;
        chan_t side_prev;
        rem_t  trial;
        rem_t  rem_next;
        quot_t quot_next;

        if (k == 0) begin : g_head
            assign rem_prev  = DIV_NUM;
            assign quot_prev = '0;
            assign div_prev  = div_in;
            assign side_prev = side_in;
        end
        else begin : g_body
            assign rem_prev  = rem_reg[k-1];
            assign quot_prev = quot_reg[k-1];
            assign div_prev  = div_reg[k-1];
            assign side_prev = side_reg[k-1];
        end

        always_comb
        begin
            trial     = rem_t'({5'b00000, div_prev}) << BIT;
            rem_next  = rem_prev;
            quot_next = quot_prev;
            if (rem_prev >= trial) begin
                rem_next       = rem_prev - trial;
                quot_next[BIT] = 1'b1;
            end
        end

        always_ff @(posedge clk)
        begin
            if (adv[k]) begin
                rem_reg[k]  <= rem_next;
                quot_reg[k] <= quot_next;
                div_reg[k]  <= div_prev;
                side_reg[k] <= side_prev;
            end
        end
    end

    assign quot_out = quot_reg[QUOT_BITS-1];
    assign side_out = side_reg[QUOT_BITS-1];

endmodule

FILE: rtl/core/rgb_pwm_segment_planner.sv
// Channel  Role  Handshake     Word
// color    in    valid/ready   red_level, green_level, blue_level (8 bits each)
// cfg      in    valid/ready   current_limit_enable (1 bit, always ready)
// plan     out   valid/ready   three (time, cumulative mask) segment pairs
//
// Thirteen register stages. One color enters per cycle while the output does not
// stall; the six-stage divider, one quotient bit per stage, sets the depth.
// Reset clears all stage valid bits and sets limiting on. A stage takes a new
// word whenever it is empty or its successor moves, so a stall at the output
// backs up only the stages that hold words and nothing is lost.
module rgb_pwm_segment_planner
    import rpsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    rpsp_color_if.sink  color,
    rpsp_cfg_if.sink    cfg,
    rpsp_plan_if.source plan
);

    // Stage map: 0 gamma, 1 blue scale, 2 sum and limit decision,
    // 3..8 divider, 9 channel scaling, 10..12 sort network and masks.
    localparam int NUM_STAGES = 13;
    localparam int DIV_FIRST  = 3;
    localparam int SCALE_STG  = DIV_FIRST + QUOT_BITS;

    // Limit enable register; user writes it only while pipeline empty, unchecked.
    logic limit_en_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            limit_en_reg <= 1'b1;
        end
        else if (cfg.valid) begin
            limit_en_reg <= cfg.current_limit_enable;
        end
    end

    assign cfg.ready = 1'b1;

    // Valid bits and stage advance. A stage loads when it is empty or when the
    // stage after it is loading too; the last stage looks at the output ready.
    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] adv;
    logic [NUM_STAGES-1:0] valid_prev;

    assign adv[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || plan.ready;
    for (genvar k = 0; k < NUM_STAGES - 1; k++) begin : g_adv
        assign adv[k] = !valid_reg[k] || adv[k+1];
    end

    assign valid_prev = {valid_reg[NUM_STAGES-2:0], color.valid};

    always_comb
    begin
        for (int k = 0; k < NUM_STAGES; k++) begin
            valid_next[k] = adv[k] ? valid_prev[k] : valid_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= '0;
        end
        else begin
            valid_reg <= valid_next;
        end
    end

    assign color.ready = adv[0];

    // Stage 0: gamma expansion of all three channels.
    duty_t red_g_reg;
    duty_t green_g_reg;
    duty_t blue_g_reg;

    always_ff @(posedge clk)
    begin
        if (adv[0]) begin
            red_g_reg   <= gamma_expand(color.red_level);
            green_g_reg <= gamma_expand(color.green_level);
            blue_g_reg  <= gamma_expand(color.blue_level);
        end
    end

    // Stage 1: blue is trimmed to 14/16 of its value plus one step.
    duty_t red_b_reg;
    duty_t green_b_reg;
    duty_t blue_b_reg;

    always_ff @(posedge clk)
    begin
        if (adv[1]) begin
            red_b_reg   <= red_g_reg;
            green_b_reg <= green_g_reg;
            blue_b_reg  <= blue_scale(blue_g_reg);
        end
    end

    // Stage 2: the summed duty decides whether the color gets scaled down.
    sum_t  sum_next;
    sum_t  sum_reg;
    chan_t chan_reg;

    assign sum_next = {2'b00, red_b_reg} + {2'b00, green_b_reg} + {2'b00, blue_b_reg};

    always_ff @(posedge clk)
    begin
        if (adv[2]) begin
            sum_reg        <= sum_next;
            chan_reg.red   <= red_b_reg;
            chan_reg.green <= green_b_reg;
            chan_reg.blue  <= blue_b_reg;
            chan_reg.limit <= limit_en_reg && (sum_next > LIMIT_SUM);
        end
    end

    // Stages 3 to 8: the scale factor floor(102400 / sum). When the color is not
    // limited the quotient is meaningless and is ignored below.
    quot_t factor;
    chan_t chan_div;

    rpsp_divider u_divider (
        .clk      (clk),
        .adv      (adv[DIV_FIRST +: QUOT_BITS]),
        .div_in   (sum_reg),
        .side_in  (chan_reg),
        .quot_out (factor),
        .side_out (chan_div)
    );

    // Stage 9: each channel is multiplied by factor / 64 with truncation.
    logic [15:0] red_prod;
    logic [15:0] green_prod;
    logic [15:0] blue_prod;
    duty_t       red_s_reg;
    duty_t       green_s_reg;
    duty_t       blue_s_reg;

    assign red_prod   = {6'b000000, chan_div.red}   * {10'b0000000000, factor};
    assign green_prod = {6'b000000, chan_div.green} * {10'b0000000000, factor};
    assign blue_prod  = {6'b000000, chan_div.blue}  * {10'b0000000000, factor};

    always_ff @(posedge clk)
    begin
        if (adv[SCALE_STG]) begin
            red_s_reg   <= chan_div.limit ? red_prod[15:6]   : chan_div.red;
            green_s_reg <= chan_div.limit ? green_prod[15:6] : chan_div.green;
            blue_s_reg  <= chan_div.limit ? blue_prod[15:6]  : chan_div.blue;
        end
    end

    // Stage 10: turn-on times and single-LED masks, then the red/green exchange.
    // A channel with zero duty turns on at the end of the cycle and lights nothing.
    slot_t red_slot;
    slot_t green_slot;
    slot_t blue_slot;
    slot_t sa_reg [3];

    assign red_slot.tm   = FULL_TIME - red_s_reg;
    assign red_slot.mk   = (red_s_reg != '0) ? MASK_RED : '0;
    assign green_slot.tm = FULL_TIME - green_s_reg;
    assign green_slot.mk = (green_s_reg != '0) ? MASK_GREEN : '0;
    assign blue_slot.tm  = FULL_TIME - blue_s_reg;
    assign blue_slot.mk  = (blue_s_reg != '0) ? MASK_BLUE : '0;

    always_ff @(posedge clk)
    begin
        if (adv[SCALE_STG+1]) begin
            if (slot_swap(red_slot, green_slot)) begin
                sa_reg[0] <= green_slot;
                sa_reg[1] <= red_slot;
            end
            else begin
                sa_reg[0] <= red_slot;
                sa_reg[1] <= green_slot;
            end
            sa_reg[2] <= blue_slot;
        end
    end

    // Stage 11: exchange of the first and last slots.
    slot_t sb_reg [3];

    always_ff @(posedge clk)
    begin
        if (adv[SCALE_STG+2]) begin
            if (slot_swap(sa_reg[0], sa_reg[2])) begin
                sb_reg[0] <= sa_reg[2];
                sb_reg[2] <= sa_reg[0];
            end
            else begin
                sb_reg[0] <= sa_reg[0];
                sb_reg[2] <= sa_reg[2];
            end
            sb_reg[1] <= sa_reg[1];
        end
    end

    // Stage 12: exchange of the middle and last slots, then the masks become
    // cumulative so each segment lists every LED that is on from its time.
    slot_t mid_slot;
    slot_t last_slot;
    slot_t so_reg [3];

    always_comb
    begin
        if (slot_swap(sb_reg[1], sb_reg[2])) begin
            mid_slot  = sb_reg[2];
            last_slot = sb_reg[1];
        end
        else begin
            mid_slot  = sb_reg[1];
            last_slot = sb_reg[2];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[SCALE_STG+3]) begin
            so_reg[0].tm <= sb_reg[0].tm;
            so_reg[0].mk <= sb_reg[0].mk;
            so_reg[1].tm <= mid_slot.tm;
            so_reg[1].mk <= sb_reg[0].mk | mid_slot.mk;
            so_reg[2].tm <= last_slot.tm;
            so_reg[2].mk <= sb_reg[0].mk | mid_slot.mk | last_slot.mk;
        end
    end

    assign plan.valid       = valid_reg[NUM_STAGES-1];
    assign plan.first_time  = so_reg[0].tm;
    assign plan.first_mask  = so_reg[0].mk;
    assign plan.second_time = so_reg[1].tm;
    assign plan.second_mask = so_reg[1].mk;
    assign plan.third_time  = so_reg[2].tm;
    assign plan.third_mask  = so_reg[2].mk;

endmodule
